/* rtl/core/gdd_pkg.sv */
// Shared types, codes and calendar helpers for the Gregorian date decrement block.
// No dependencies; used by gdd_ctrl, gdd_datapath and gregorian_date_decrement_core.
`default_nettype none

package gdd_pkg;

	// Unit codes carried by the action field.
	localparam logic [2:0] ACT_DAY        = 3'd0;
	localparam logic [2:0] ACT_WEEK       = 3'd1;
	localparam logic [2:0] ACT_MONTH      = 3'd2;
	localparam logic [2:0] ACT_YEAR       = 3'd3;
	localparam logic [2:0] ACT_DECADE     = 3'd4;
	localparam logic [2:0] ACT_CENTURY    = 3'd5;
	localparam logic [2:0] ACT_MILLENNIUM = 3'd6;

	// Reciprocal of twelve scaled by 2^19, used to split a month count into years.
	localparam logic [15:0] RECIP12      = 16'd43691;
	localparam int          RECIP12_SHIFT = 19;

	// Inverse of 25 modulo 2^14 and the largest residue of a multiple of 25.
	localparam logic [13:0] INV25_MOD14  = 14'd7209;
	localparam logic [13:0] DIV25_LIMIT  = 14'd655;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DAYS,
		ST_MONTHS,
		ST_YEARS,
		ST_FINISH
	} gdd_state_t;

	typedef struct packed {
		logic load;
		logic check;
		logic day_step;
		logic apply;
		logic emit;
	} gdd_cmd_t;

	typedef struct packed {
		logic bad;
		logic is_day;
		logic is_month;
		logic is_years;
		logic days_done;
	} gdd_stat_t;

	// Length of a month, or zero for a month code outside 1 to 12.
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/gregorian_date_decrement_core.sv */
// Top level of the Gregorian date decrement block.
// Depends on gdd_pkg, gdd_ctrl and gdd_datapath.
//
// Channel  Handshake               Payload
// input    in_valid / in_stall     action, amount, day_in, month_in, year_in
// output   out_valid / out_stall   day_out, month_out, year_out, bad_date, year_underflow
//
// After its accepting cycle an item passes the check state, then for day and week units
// the day walk, at one cycle per month crossed, until the count ends inside a month or
// the year underflows, one apply state for the other units and nothing more for a bad date
// or an unused unit code, then the finish state that loads the output register.
// Reset clears the controller and the output valid; the date registers need none.
// A new item is taken while the previous result still waits under out_stall.
`default_nettype none

module gregorian_date_decrement_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [15:0] amount,
	input  wire logic [4:0]  day_in,
	input  wire logic [3:0]  month_in,
	input  wire logic [13:0] year_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       day_out,
	output logic [3:0]       month_out,
	output logic [13:0]      year_out,
	output logic             bad_date,
	output logic             year_underflow
);

	gdd_pkg::gdd_cmd_t  cmd;
	gdd_pkg::gdd_stat_t stat;

	gdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	gdd_datapath u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.amount         (amount),
		.day_in         (day_in),
		.month_in       (month_in),
		.year_in        (year_in),
		.day_out        (day_out),
		.month_out      (month_out),
		.year_out       (year_out),
		.bad_date       (bad_date),
		.year_underflow (year_underflow)
	);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// Once an item is taken, no further item may enter until it is finished.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input taken while an item is still in work");

	// An underflowed result is always the first of January, year zero.
	a_underflow_date: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && year_underflow) |->
		(day_out == 5'd1 && month_out == 4'd1 && year_out == 14'd0))
		else $error("underflow result is not 1/1/0");

	// The two flags exclude each other.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(bad_date && year_underflow))
		else $error("bad date and underflow both set");

	// A fresh result only appears when the block had an item in work.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

endmodule

`default_nettype wire

/* rtl/core/gdd_ctrl.sv */
// Controller state machine of the Gregorian date decrement block.
// Depends on gdd_pkg; drives gdd_datapath through gdd_cmd_t.
`default_nettype none

module gdd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire gdd_pkg::gdd_stat_t stat,
	output gdd_pkg::gdd_cmd_t      cmd
);

	gdd_pkg::gdd_state_t state_q, state_d;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gdd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gdd_pkg::ST_IDLE: begin
				if (in_valid) state_d = gdd_pkg::ST_CHECK;
			end
			gdd_pkg::ST_CHECK: begin
				if (stat.bad)           state_d = gdd_pkg::ST_FINISH;
				else if (stat.is_day)   state_d = gdd_pkg::ST_DAYS;
				else if (stat.is_month) state_d = gdd_pkg::ST_MONTHS;
				else if (stat.is_years) state_d = gdd_pkg::ST_YEARS;
				else                    state_d = gdd_pkg::ST_FINISH;
			end
			gdd_pkg::ST_DAYS: begin
				if (stat.days_done) state_d = gdd_pkg::ST_FINISH;
			end
			gdd_pkg::ST_MONTHS: state_d = gdd_pkg::ST_FINISH;
			gdd_pkg::ST_YEARS:  state_d = gdd_pkg::ST_FINISH;
			gdd_pkg::ST_FINISH: begin
				if (out_free) state_d = gdd_pkg::ST_IDLE;
			end
			default: state_d = gdd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_stall     = 1'b1;
		cmd.load     = 1'b0;
		case (state_q)
			gdd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			gdd_pkg::ST_CHECK:  cmd.check    = 1'b1;
			gdd_pkg::ST_DAYS:   cmd.day_step = !stat.days_done;
			gdd_pkg::ST_MONTHS: cmd.apply    = 1'b1;
			gdd_pkg::ST_YEARS:  cmd.apply    = 1'b1;
			gdd_pkg::ST_FINISH: cmd.emit     = out_free;
			default:            cmd          = '0;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/gdd_datapath.sv */
// Datapath of the Gregorian date decrement block: date registers, month stepper,
// leap test, unit multiplier and output register. Depends on gdd_pkg.
`default_nettype none

module gdd_datapath (
	input  wire logic              clk,
	input  wire gdd_pkg::gdd_cmd_t cmd,
	output gdd_pkg::gdd_stat_t     stat,
	input  wire logic [2:0]        action,
	input  wire logic [15:0]       amount,
	input  wire logic [4:0]        day_in,
	input  wire logic [3:0]        month_in,
	input  wire logic [13:0]       year_in,
	output logic [4:0]             day_out,
	output logic [3:0]             month_out,
	output logic [13:0]            year_out,
	output logic                   bad_date,
	output logic                   year_underflow
);

	logic [2:0]  action_q;
	logic [15:0] amount_q;
	logic [18:0] left_q;
	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [13:0] y_q;
	logic [31:0] prod_q;
	logic        bad_q;
	logic        under_q;

	// Leap test on the working year: divisible by 4, and not by 100 unless by 400.
	// Divisibility by 25 uses the modular inverse of 25.
	logic [27:0] inv_prod;
	logic        div25;
	logic        leap;
	logic [4:0]  cur_len;
	logic [4:0]  prev_len;
	logic [3:0]  m_prev;

	assign inv_prod = {14'd0, y_q} * {14'd0, gdd_pkg::INV25_MOD14};
	assign div25    = inv_prod[13:0] <= gdd_pkg::DIV25_LIMIT;
	assign leap     = (y_q[1:0] == 2'd0) && (!div25 || (y_q[3:0] == 4'd0));
	assign m_prev   = m_q - 4'd1;
	assign cur_len  = gdd_pkg::month_len(m_q, leap);
	assign prev_len = gdd_pkg::month_len(m_prev, leap);

	logic is_day, is_month, is_years;
	assign is_day   = (action_q == gdd_pkg::ACT_DAY) || (action_q == gdd_pkg::ACT_WEEK);
	assign is_month = (action_q == gdd_pkg::ACT_MONTH);
	assign is_years = (action_q == gdd_pkg::ACT_YEAR) || (action_q == gdd_pkg::ACT_DECADE) ||
	                  (action_q == gdd_pkg::ACT_CENTURY) ||
	                  (action_q == gdd_pkg::ACT_MILLENNIUM);

	assign stat.bad       = (cur_len == 5'd0) || (d_q == 5'd0) || (d_q > cur_len);
	assign stat.is_day    = is_day;
	assign stat.is_month  = is_month;
	assign stat.is_years  = is_years;
	assign stat.days_done = (left_q == 19'd0) || under_q;

	// Per-unit factor for the multiplier; for months it is the reciprocal of twelve.
	logic [15:0] factor;
	always_comb begin
		case (action_q)
			gdd_pkg::ACT_MONTH:      factor = gdd_pkg::RECIP12;
			gdd_pkg::ACT_YEAR:       factor = 16'd1;
			gdd_pkg::ACT_DECADE:     factor = 16'd10;
			gdd_pkg::ACT_CENTURY:    factor = 16'd100;
			gdd_pkg::ACT_MILLENNIUM: factor = 16'd1000;
			default:                 factor = 16'd0;
		endcase
	end

	// Month units: split the count into whole years and remaining months.
	logic [12:0] yrs;
	logic [15:0] yrs12;
	logic [15:0] rem16;
	logic [3:0]  mb;
	logic [3:0]  m0;
	logic        borrow;
	logic [13:0] ysub;
	logic [3:0]  m_new;
	logic        mon_under;
	logic [25:0] sub;
	logic        yr_under;

	assign yrs       = prod_q[gdd_pkg::RECIP12_SHIFT +: 13];
	assign yrs12     = {yrs, 3'd0} + {1'b0, yrs, 2'd0};
	assign rem16     = amount_q - yrs12;
	assign mb        = rem16[3:0];
	assign m0        = m_q - 4'd1;
	assign borrow    = mb > m0;
	assign ysub      = {1'b0, yrs} + {13'd0, borrow};
	assign m_new     = borrow ? (m0 + 4'd13 - mb) : (m0 - mb + 4'd1);
	assign mon_under = ysub > y_q;
	assign sub       = prod_q[25:0];
	assign yr_under  = sub > {12'd0, y_q};

	logic [18:0] left_load;
	assign left_load = (action == gdd_pkg::ACT_WEEK) ?
	                   ({amount, 3'd0} - {3'd0, amount}) : {3'd0, amount};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			amount_q <= amount;
			left_q   <= left_load;
			d_q      <= day_in;
			m_q      <= month_in;
			y_q      <= year_in;
			bad_q    <= 1'b0;
			under_q  <= 1'b0;
		end
		if (cmd.check) begin
			bad_q  <= stat.bad;
			prod_q <= {16'd0, amount_q} * {16'd0, factor};
		end
		if (cmd.day_step) begin
			// Either the count ends inside this month, or the whole month is skipped.
			if (left_q < {14'd0, d_q}) begin
				d_q    <= d_q - left_q[4:0];
				left_q <= 19'd0;
			end else begin
				left_q <= left_q - {14'd0, d_q};
				if (m_q == 4'd1) begin
					if (y_q == 14'd0) begin
						under_q <= 1'b1;
					end else begin
						y_q <= y_q - 14'd1;
						m_q <= 4'd12;
						d_q <= 5'd31;
					end
				end else begin
					m_q <= m_prev;
					d_q <= prev_len;
				end
			end
		end
		if (cmd.apply) begin
			if (is_month) begin
				if (mon_under) begin
					under_q <= 1'b1;
				end else begin
					y_q <= y_q - ysub;
					m_q <= m_new;
				end
			end else begin
				if (yr_under) begin
					under_q <= 1'b1;
				end else begin
					y_q <= y_q - sub[13:0];
				end
			end
		end
		if (cmd.emit) begin
			day_out        <= under_q ? 5'd1 : d_q;
			month_out      <= under_q ? 4'd1 : m_q;
			year_out       <= under_q ? 14'd0 : y_q;
			bad_date       <= bad_q;
			year_underflow <= under_q;
		end
	end

endmodule

`default_nettype wire

/* test/tb_gregorian_date_decrement_core.sv */
// Self-checking testbench for gregorian_date_decrement_core: directed date table, then random items.
// Depends on gdd_pkg for the unit codes; results are compared with a local calendar predictor.
`timescale 1ns / 100ps

module tb_gregorian_date_decrement_core;

	localparam logic [2:0] ACT_UNUSED     = 3'd7;
	localparam int         RANDOM_ITEMS   = 1150;
	localparam int         WATCHDOG_LIMIT = 60000;
	localparam int         DRAIN_CYCLES   = 40;
	localparam int         LONG_HOLD      = 400;
	localparam int         HOLD_AT_RESULT = 300;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] amount;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} date_req_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic        bad;
		logic        under;
	} date_res_t;

	typedef struct {
		bit        known;
		date_req_t req;
		date_res_t res;
	} date_case_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [15:0] amount;
	logic [4:0]  day_in;
	logic [3:0]  month_in;
	logic [13:0] year_in;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  day_out;
	logic [3:0]  month_out;
	logic [13:0] year_out;
	logic        bad_date;
	logic        year_underflow;

	date_res_t   pending_dates[$];
	date_case_t  date_cases[$];
	int unsigned error_count;
	int unsigned results_taken;
	int unsigned idle_cycles;
	bit          steady;

	gregorian_date_decrement_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.amount         (amount),
		.day_in         (day_in),
		.month_in       (month_in),
		.year_in        (year_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.day_out        (day_out),
		.month_out      (month_out),
		.year_out       (year_out),
		.bad_date       (bad_date),
		.year_underflow (year_underflow)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		int unsigned len;
		case (m)
			1, 3, 5, 7, 8, 10, 12: len = 31;
			4, 6, 9, 11:           len = 30;
			2:                     len = leap_year(y) ? 29 : 28;
			default:               len = 0;
		endcase
		return len;
	endfunction

	function automatic date_res_t predict_decrement(input date_req_t r);
		int unsigned d, m, y, left, total, mult, sub, amt;
		bit          bad, under;
		date_res_t   res;
		d = 32'(r.day);
		m = 32'(r.month);
		y = 32'(r.year);
		amt = 32'(r.amount);
		bad = 1'b0;
		under = 1'b0;
		if (m < 1 || m > 12 || d < 1 || d > month_days(m, y)) begin
			bad = 1'b1;
		end else if (r.action == gdd_pkg::ACT_DAY || r.action == gdd_pkg::ACT_WEEK) begin
			// Walk back a whole month at a time until the remainder fits in the current month.
			left = (r.action == gdd_pkg::ACT_DAY) ? amt : amt * 7;
			while (left > 0) begin
				if (left < d) begin
					d = d - left;
					left = 0;
				end else begin
					left = left - d;
					if (m == 1) begin
						if (y == 0) begin
							under = 1'b1;
							break;
						end
						y = y - 1;
						m = 12;
					end else begin
						m = m - 1;
					end
					d = month_days(m, y);
				end
			end
		end else if (r.action == gdd_pkg::ACT_MONTH) begin
			total = y * 12 + (m - 1);
			if (amt > total) begin
				under = 1'b1;
			end else begin
				total = total - amt;
				y = total / 12;
				m = total % 12 + 1;
			end
		end else if (r.action != ACT_UNUSED) begin
			case (r.action)
				gdd_pkg::ACT_YEAR:    mult = 1;
				gdd_pkg::ACT_DECADE:  mult = 10;
				gdd_pkg::ACT_CENTURY: mult = 100;
				default:              mult = 1000;
			endcase
			sub = amt * mult;
			if (sub > y)
				under = 1'b1;
			else
				y = y - sub;
		end
		if (under) begin
			d = 1;
			m = 1;
			y = 0;
		end
		res.day = d[4:0];
		res.month = m[3:0];
		res.year = y[13:0];
		res.bad = bad;
		res.under = under;
		return res;
	endfunction

	function automatic void add_known(input logic [2:0] a, input int unsigned amt,
			input int unsigned d, input int unsigned m, input int unsigned y,
			input int unsigned ed, input int unsigned em, input int unsigned ey,
			input bit eb, input bit eu);
		date_case_t c;
		c.known = 1'b1;
		c.req = '{action: a, amount: amt[15:0], day: d[4:0], month: m[3:0], year: y[13:0]};
		c.res = '{day: ed[4:0], month: em[3:0], year: ey[13:0], bad: eb, under: eu};
		date_cases.push_back(c);
	endfunction

	function automatic void add_calc(input logic [2:0] a, input int unsigned amt,
			input int unsigned d, input int unsigned m, input int unsigned y);
		date_case_t c;
		c.known = 1'b0;
		c.req = '{action: a, amount: amt[15:0], day: d[4:0], month: m[3:0], year: y[13:0]};
		c.res = '0;
		date_cases.push_back(c);
	endfunction

	function automatic date_req_t random_request();
		date_req_t   q;
		int unsigned pick, len, cap;
		q.action = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 9);
		if (pick < 2)
			q.year = 14'($urandom_range(0, 4));
		else if (pick < 4)
			q.year = 14'(100 * $urandom_range(0, 163));
		else
			q.year = 14'($urandom_range(0, 16383));
		q.month = 4'($urandom_range(1, 12));
		len = month_days(32'(q.month), 32'(q.year));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			q.day = 5'd1;
		else if (pick == 1)
			q.day = len[4:0];
		else
			q.day = 5'($urandom_range(1, len));
		// A tenth of the items carry a broken date.
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 1) == 1)
				q.month = 4'($urandom_range(0, 15));
			q.day = 5'($urandom_range(0, 31));
		end
		pick = $urandom_range(0, 19);
		if (pick == 0 || q.action == ACT_UNUSED) begin
			q.amount = 16'($urandom_range(0, 65535));
		end else begin
			// Day and week walks take a cycle per month, so most amounts stay small.
			case (q.action)
				gdd_pkg::ACT_DAY, gdd_pkg::ACT_WEEK: cap = (pick < 6) ? 1000 : 40;
				gdd_pkg::ACT_MONTH:   cap = 32'(q.year) * 12 + 14;
				gdd_pkg::ACT_YEAR:    cap = 32'(q.year) + 2;
				gdd_pkg::ACT_DECADE:  cap = 32'(q.year) / 10 + 1;
				gdd_pkg::ACT_CENTURY: cap = 32'(q.year) / 100 + 1;
				default:              cap = 32'(q.year) / 1000 + 1;
			endcase
			if (cap > 65535)
				cap = 65535;
			q.amount = 16'($urandom_range(0, cap));
		end
		return q;
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR at %0t ns: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic offer_request(input date_req_t q, input date_res_t want);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= q.action;
		amount   <= q.amount;
		day_in   <= q.day;
		month_in <= q.month;
		year_in  <= q.year;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_dates.push_back(want);
	endtask

	task automatic check_result();
		date_res_t want;
		if (pending_dates.size() == 0) begin
			flag_error($sformatf("result %0d/%0d/%0d arrived with nothing expected",
				day_out, month_out, year_out));
		end else begin
			want = pending_dates.pop_front();
			if (day_out !== want.day)
				flag_error($sformatf("result %0d: day_out %0d, expected %0d",
					results_taken, day_out, want.day));
			if (month_out !== want.month)
				flag_error($sformatf("result %0d: month_out %0d, expected %0d",
					results_taken, month_out, want.month));
			if (year_out !== want.year)
				flag_error($sformatf("result %0d: year_out %0d, expected %0d",
					results_taken, year_out, want.year));
			if (bad_date !== want.bad)
				flag_error($sformatf("result %0d: bad_date %0b, expected %0b",
					results_taken, bad_date, want.bad));
			if (year_underflow !== want.under)
				flag_error($sformatf("result %0d: year_underflow %0b, expected %0b",
					results_taken, year_underflow, want.under));
		end
	endtask

	// Result side: random hold-off per item outside the steady blocks, with one long stretch to back the block up.
	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		results_taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 9);
			if (results_taken == HOLD_AT_RESULT)
				hold = LONG_HOLD;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			check_result();
			results_taken++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		date_res_t want;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		amount = '0;
		day_in = '0;
		month_in = '0;
		year_in = '0;
		steady = 1'b0;
		error_count = 0;

		add_known(gdd_pkg::ACT_DAY,      0, 15,  6,  2020, 15,  6,  2020, 1'b0, 1'b0);
		add_known(ACT_UNUSED,          100, 10,  3,  2000, 10,  3,  2000, 1'b0, 1'b0);
		add_known(gdd_pkg::ACT_DAY,      5,  1,  0,  2000,  1,  0,  2000, 1'b1, 1'b0);
		add_known(gdd_pkg::ACT_MONTH,    3,  1, 13,     5,  1, 13,     5, 1'b1, 1'b0);
		add_known(gdd_pkg::ACT_YEAR, 65535, 31, 15, 16383, 31, 15, 16383, 1'b1, 1'b0);
		add_known(gdd_pkg::ACT_WEEK,     1,  0,  5,   100,  0,  5,   100, 1'b1, 1'b0);
		add_known(gdd_pkg::ACT_DAY,      1, 29,  2,  1900, 29,  2,  1900, 1'b1, 1'b0);
		add_known(gdd_pkg::ACT_CENTURY,  1, 31,  4,  2021, 31,  4,  2021, 1'b1, 1'b0);
		add_known(gdd_pkg::ACT_DAY,      1, 29,  2,  2000, 28,  2,  2000, 1'b0, 1'b0);
		add_known(gdd_pkg::ACT_DAY,      1,  1,  1,     0,  1,  1,     0, 1'b0, 1'b1);
		add_known(gdd_pkg::ACT_MONTH,    1, 31,  1,     0,  1,  1,     0, 1'b0, 1'b1);
		add_known(gdd_pkg::ACT_YEAR, 65535,  1,  1,  9999,  1,  1,     0, 1'b0, 1'b1);
		add_known(gdd_pkg::ACT_YEAR,     1, 29,  2,  2000, 29,  2,  1999, 1'b0, 1'b0);
		add_known(gdd_pkg::ACT_DECADE,   1,  5,  5,    10,  5,  5,     0, 1'b0, 1'b0);
		add_known(gdd_pkg::ACT_MILLENNIUM, 16,  7, 7, 16383, 7,  7,   383, 1'b0, 1'b0);
		add_known(gdd_pkg::ACT_MILLENNIUM, 65535, 28, 2, 16383, 1, 1,  0, 1'b0, 1'b1);
		add_calc(gdd_pkg::ACT_DAY,       1,  1,  3,  2024);
		add_calc(gdd_pkg::ACT_DAY,       1,  1,  1,  2000);
		add_calc(gdd_pkg::ACT_DAY,       5,  5,  3,  2020);
		add_calc(gdd_pkg::ACT_DAY,     366, 31, 12,  2000);
		add_calc(gdd_pkg::ACT_WEEK,  65535, 31, 12, 16383);
		add_calc(gdd_pkg::ACT_DAY,   65535, 31, 12,  9999);
		add_calc(gdd_pkg::ACT_MONTH,     1, 15,  1,  2000);
		add_calc(gdd_pkg::ACT_MONTH, 65535, 31, 12, 16383);
		add_calc(gdd_pkg::ACT_CENTURY, 163,  1,  6, 16383);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (date_cases[i]) begin
			want = date_cases[i].known ? date_cases[i].res : predict_decrement(date_cases[i].req);
			offer_request(date_cases[i].req, want);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			date_req_t q;
			// Every fourth block of a hundred items runs with neither side idling.
			steady = ((i / 100) % 4 == 3);
			q = random_request();
			offer_request(q, predict_decrement(q));
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (pending_dates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/gdd_pkg.sv
rtl/core/gdd_ctrl.sv
rtl/core/gdd_datapath.sv
rtl/core/gregorian_date_decrement_core.sv
test/tb_gregorian_date_decrement_core.sv
